/* rtl/core/v3alu_pkg.sv */
package v3alu_pkg;

    localparam int WORD_W = 32;
    localparam int ACC_W  = 2 * WORD_W + 3;

    localparam logic [2:0] OP_DOT   = 3'd0;
    localparam logic [2:0] OP_CROSS = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_SUB   = 3'd3;
    localparam logic [2:0] OP_SCALE = 3'd4;
    localparam logic [2:0] OP_DIV   = 3'd5;
    localparam logic [2:0] OP_NORM  = 3'd6;
    localparam logic [2:0] OP_NOP   = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [2:0] operation;
        word_t      ax;
        word_t      ay;
        word_t      az;
        word_t      bx;
        word_t      by;
        word_t      bz;
        word_t      scalar;
    } v3alu_in_t;

    typedef struct packed {
        word_t rx;
        word_t ry;
        word_t rz;
        logic  fault;
    } v3alu_out_t;

    function automatic word_t sat_ext(input logic signed [ACC_W:0] t);
        word_t r;
        if (t[ACC_W] == 1'b0 && (|t[ACC_W-1:WORD_W-1]))
            r = WORD_MAX;
        else if (t[ACC_W] == 1'b1 && !(&t[ACC_W-1:WORD_W-1]))
            r = WORD_MIN;
        else
            r = t[WORD_W-1:0];
        return r;
    endfunction

    function automatic word_t rnd_sat(input logic signed [ACC_W-1:0] x, input int f);
        logic signed [ACC_W:0] t;
        t = {x[ACC_W-1], x} + ((ACC_W+1)'(1) << (f - 1));
        t = t >>> f;
        return sat_ext(t);
    endfunction

    function automatic logic [WORD_W-1:0] mag(input word_t x);
        logic [WORD_W-1:0] u;
        u = x;
        return u[WORD_W-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

/* rtl/core/vector3_arithmetic_unit.sv */
// Three-component vector ALU on signed Q-format words (FRAC_BITS fraction bits):
// dot, cross, add, sub, scale, divide by scalar and normalize. One word is taken
// every cycle; busy stays low. Every operation takes the same path through the
// pipeline, set by the one-bit-per-stage square root (WORD_W stages) and the
// one-bit-per-stage dividers (WORD_W+FRAC_BITS stages plus rounding), which all
// operations pass through or match with delay lines, so results keep order.
// done marks the result for a single cycle and cannot be held off. Divide by zero
// and normalize of a zero vector return a zero vector with fault set.
module vector3_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  v3alu_pkg::v3alu_in_t   operand,
    output logic                   done,
    output v3alu_pkg::v3alu_out_t  result
);
    import v3alu_pkg::*;

    localparam int W  = WORD_W;
    localparam int NW = WORD_W + FRAC_BITS;

    typedef struct packed {
        logic         valid;
        logic [2:0]   op;
        logic         fault;
        logic [2:0]   neg;
        logic [W-1:0] smag;
        logic [3*W-1:0] amag;
        logic [3*W-1:0] res;
    } dl1_t;

    typedef struct packed {
        logic         valid;
        logic [2:0]   op;
        logic         fault;
        logic [3*W-1:0] res;
    } dl2_t;

    word_t av_in [0:2];
    word_t bv_in [0:2];
    word_t m0a [0:2];
    word_t m0b [0:2];
    word_t m1a [0:2];
    word_t m1b [0:2];
    logic signed [ACC_W-1:0] lane_acc [0:2];
    word_t lane_rnd [0:2];

    logic      a_valid_reg, b_valid_reg, c_valid_reg;
    logic      a_fault_reg, b_fault_reg, c_fault_reg;
    logic      fault_next;
    v3alu_in_t a_reg, b_reg, c_reg;
    logic signed [ACC_W-1:0] c_sum_reg;
    word_t     c_pre_reg [0:2];
    word_t     pre_next [0:2];
    word_t     bav [0:2];
    word_t     bbv [0:2];

    dl1_t dl1_next;
    dl1_t dl1_reg [0:W-1];
    dl2_t dl2_reg [0:NW];
    dl1_t dl1_out;
    dl2_t dl2_out;

    logic [W-1:0] root;
    logic [W-1:0] den;
    word_t        quot [0:2];

    logic       done_reg;
    v3alu_out_t result_reg;
    v3alu_out_t result_next;

    assign busy = 1'b0;

    assign av_in[0] = operand.ax;
    assign av_in[1] = operand.ay;
    assign av_in[2] = operand.az;
    assign bv_in[0] = operand.bx;
    assign bv_in[1] = operand.by;
    assign bv_in[2] = operand.bz;

    assign fault_next = (operand.operation == OP_DIV && operand.scalar == '0)
                     || (operand.operation == OP_NORM && operand.ax == '0
                         && operand.ay == '0 && operand.az == '0);

    for (genvar i = 0; i < 3; i++)
    begin : gen_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        always_comb
        begin
            m1a[i] = av_in[K];
            m1b[i] = bv_in[J];
            unique case (operand.operation)
                OP_CROSS:
                begin
                    m0a[i] = av_in[J];
                    m0b[i] = bv_in[K];
                end
                OP_SCALE:
                begin
                    m0a[i] = av_in[i];
                    m0b[i] = operand.scalar;
                end
                OP_NORM:
                begin
                    m0a[i] = av_in[i];
                    m0b[i] = av_in[i];
                end
                default:
                begin
                    m0a[i] = av_in[i];
                    m0b[i] = bv_in[i];
                end
            endcase
        end

        v3alu_mul_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_mul (
            .clk     (clk),
            .m0a     (m0a[i]),
            .m0b     (m0b[i]),
            .m1a     (m1a[i]),
            .m1b     (m1b[i]),
            .sub     (operand.operation == OP_CROSS),
            .acc     (lane_acc[i]),
            .rounded (lane_rnd[i])
        );

        always_comb
        begin
            unique case (b_reg.operation)
                OP_CROSS, OP_SCALE:
                    pre_next[i] = lane_rnd[i];
                OP_ADD:
                    pre_next[i] = sat_ext((ACC_W+1)'(bav[i]) + (ACC_W+1)'(bbv[i]));
                OP_SUB:
                    pre_next[i] = sat_ext((ACC_W+1)'(bav[i]) - (ACC_W+1)'(bbv[i]));
                default:
                    pre_next[i] = '0;
            endcase
        end

        v3alu_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk  (clk),
            .num  (dl1_out.amag[W*i +: W]),
            .den  (den),
            .neg  (dl1_out.neg[i]),
            .quot (quot[i])
        );
    end

    assign bav[0] = b_reg.ax;
    assign bav[1] = b_reg.ay;
    assign bav[2] = b_reg.az;
    assign bbv[0] = b_reg.bx;
    assign bbv[1] = b_reg.by;
    assign bbv[2] = b_reg.bz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= operand;
        a_fault_reg  <= fault_next;
        b_reg        <= a_reg;
        b_fault_reg  <= a_fault_reg;
        c_reg        <= b_reg;
        c_fault_reg  <= b_fault_reg;
        c_sum_reg    <= lane_acc[0] + lane_acc[1] + lane_acc[2];
        c_pre_reg[0] <= pre_next[0];
        c_pre_reg[1] <= pre_next[1];
        c_pre_reg[2] <= pre_next[2];
    end

    always_comb
    begin
        dl1_next.valid = c_valid_reg;
        dl1_next.op    = c_reg.operation;
        dl1_next.fault = c_fault_reg;
        dl1_next.neg[0] = c_reg.ax[W-1] ^ (c_reg.operation == OP_DIV && c_reg.scalar[W-1]);
        dl1_next.neg[1] = c_reg.ay[W-1] ^ (c_reg.operation == OP_DIV && c_reg.scalar[W-1]);
        dl1_next.neg[2] = c_reg.az[W-1] ^ (c_reg.operation == OP_DIV && c_reg.scalar[W-1]);
        dl1_next.smag  = mag(c_reg.scalar);
        dl1_next.amag  = {mag(c_reg.az), mag(c_reg.ay), mag(c_reg.ax)};
        dl1_next.res   = {c_pre_reg[2], c_pre_reg[1],
                          (c_reg.operation == OP_DOT) ? rnd_sat(c_sum_reg, FRAC_BITS)
                                                      : c_pre_reg[0]};
    end

    v3alu_sqrt u_sqrt (
        .clk      (clk),
        .radicand (c_sum_reg[2*W-1:0]),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < W; s++)
                dl1_reg[s] <= '0;
            for (int s = 0; s <= NW; s++)
                dl2_reg[s] <= '0;
        end
        else
        begin
            dl1_reg[0] <= dl1_next;
            for (int s = 1; s < W; s++)
                dl1_reg[s] <= dl1_reg[s-1];
            dl2_reg[0] <= {dl1_out.valid, dl1_out.op, dl1_out.fault, dl1_out.res};
            for (int s = 1; s <= NW; s++)
                dl2_reg[s] <= dl2_reg[s-1];
        end
    end

    assign dl1_out = dl1_reg[W-1];
    assign dl2_out = dl2_reg[NW];
    assign den     = (dl1_out.op == OP_DIV) ? dl1_out.smag : root;

    always_comb
    begin
        if (dl2_out.fault)
            result_next = '{rx: '0, ry: '0, rz: '0, fault: 1'b1};
        else if (dl2_out.op == OP_DIV || dl2_out.op == OP_NORM)
            result_next = '{rx: quot[0], ry: quot[1], rz: quot[2], fault: 1'b0};
        else
            result_next = '{rx: dl2_out.res[W-1:0], ry: dl2_out.res[2*W-1:W],
                            rz: dl2_out.res[3*W-1:2*W], fault: 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dl2_out.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    ast_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.fault |-> result.rx == '0 && result.ry == '0 && result.rz == '0)
        else $error("fault word carries a nonzero vector");

    ast_fault_op: assert property (@(posedge clk) disable iff (!rst_n)
        dl2_out.valid && dl2_out.fault |-> dl2_out.op == OP_DIV || dl2_out.op == OP_NORM)
        else $error("fault raised on an operation that cannot fault");

    ast_dot_yz: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(dl2_out.op) == OP_DOT |-> result.ry == '0 && result.rz == '0)
        else $error("dot word has nonzero y or z");
`endif

endmodule

/* rtl/core/v3alu_mul_lane.sv */
module v3alu_mul_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  v3alu_pkg::word_t                     m0a,
    input  v3alu_pkg::word_t                     m0b,
    input  v3alu_pkg::word_t                     m1a,
    input  v3alu_pkg::word_t                     m1b,
    input  logic                                 sub,
    output logic signed [v3alu_pkg::ACC_W-1:0]   acc,
    output v3alu_pkg::word_t                     rounded
);
    import v3alu_pkg::*;

    logic signed [2*WORD_W-1:0] p0_reg;
    logic signed [2*WORD_W-1:0] p1_reg;
    logic                       sub_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    acc_reg;
    word_t                      rnd_next;
    word_t                      rnd_reg;

    always_ff @(posedge clk)
    begin
        p0_reg  <= m0a * m0b;
        p1_reg  <= m1a * m1b;
        sub_reg <= sub;
    end

    always_comb
    begin
        acc_next = ACC_W'(p0_reg) - (sub_reg ? ACC_W'(p1_reg) : ACC_W'(0));
        rnd_next = rnd_sat(acc_next, FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rnd_reg <= rnd_next;
    end

    assign acc     = acc_reg;
    assign rounded = rnd_reg;

endmodule

/* rtl/core/v3alu_sqrt.sv */
module v3alu_sqrt (
    input  logic                            clk,
    input  logic [2*v3alu_pkg::WORD_W-1:0]  radicand,
    output logic [v3alu_pkg::WORD_W-1:0]    root
);
    import v3alu_pkg::*;

    localparam int W = WORD_W;

    logic [2*W-1:0] rad_reg  [0:W-1];
    logic [W:0]     rem_reg  [0:W-1];
    logic [W-1:0]   root_reg [0:W-1];

    for (genvar g = 0; g < W; g++)
    begin : gen_step
        logic [2*W-1:0] prad;
        logic [W:0]     prem;
        logic [W-1:0]   proot;
        logic [W+2:0]   rt;
        logic [W+2:0]   trial;
        logic           ge;
        logic [W:0]     rem_next;
        logic [W-1:0]   root_next;

        if (g == 0)
        begin : gen_first
            assign prad  = radicand;
            assign prem  = '0;
            assign proot = '0;
        end
        else
        begin : gen_rest
            assign prad  = rad_reg[g-1];
            assign prem  = rem_reg[g-1];
            assign proot = root_reg[g-1];
        end

        always_comb
        begin
            rt        = {prem, prad[2*W-1:2*W-2]};
            trial     = {1'b0, proot, 2'b01};
            ge        = rt >= trial;
            rem_next  = ge ? (W+1)'(rt - trial) : rt[W:0];
            root_next = {proot[W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            rad_reg[g]  <= {prad[2*W-3:0], 2'b00};
            rem_reg[g]  <= rem_next;
            root_reg[g] <= root_next;
        end
    end

    assign root = root_reg[W-1];

endmodule

/* rtl/core/v3alu_div_lane.sv */
module v3alu_div_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic [v3alu_pkg::WORD_W-1:0]  num,
    input  logic [v3alu_pkg::WORD_W-1:0]  den,
    input  logic                          neg,
    output v3alu_pkg::word_t              quot
);
    import v3alu_pkg::*;

    localparam int W  = WORD_W;
    localparam int NW = WORD_W + FRAC_BITS;

    logic [NW-1:0] n_reg   [0:NW-1];
    logic [W-1:0]  d_reg   [0:NW-1];
    logic          neg_reg [0:NW-1];
    logic [W-1:0]  rem_reg [0:NW-1];
    logic [NW-1:0] q_reg   [0:NW-1];

    for (genvar g = 0; g < NW; g++)
    begin : gen_step
        logic [NW-1:0] pn;
        logic [W-1:0]  pd;
        logic          pneg;
        logic [W-1:0]  prem;
        logic [NW-1:0] pq;
        logic [W:0]    rt;
        logic          ge;
        logic [W-1:0]  rem_next;

        if (g == 0)
        begin : gen_first
            assign pn   = NW'(num) << FRAC_BITS;
            assign pd   = den;
            assign pneg = neg;
            assign prem = '0;
            assign pq   = '0;
        end
        else
        begin : gen_rest
            assign pn   = n_reg[g-1];
            assign pd   = d_reg[g-1];
            assign pneg = neg_reg[g-1];
            assign prem = rem_reg[g-1];
            assign pq   = q_reg[g-1];
        end

        always_comb
        begin
            rt       = {prem, pn[NW-1]};
            ge       = rt >= {1'b0, pd};
            rem_next = ge ? W'(rt - {1'b0, pd}) : rt[W-1:0];
        end

        always_ff @(posedge clk)
        begin
            n_reg[g]   <= {pn[NW-2:0], 1'b0};
            d_reg[g]   <= pd;
            neg_reg[g] <= pneg;
            rem_reg[g] <= rem_next;
            q_reg[g]   <= {pq[NW-2:0], ge};
        end
    end

    localparam logic [NW:0] LIM = (NW+1)'(1) << (W - 1);

    logic [NW:0] q1;
    logic [NW:0] nq;
    logic        half;
    word_t       quot_next;
    word_t       quot_reg;

    always_comb
    begin
        half = {rem_reg[NW-1], 1'b0} >= {1'b0, d_reg[NW-1]};
        q1   = {1'b0, q_reg[NW-1]} + (NW+1)'(half);
        nq   = (NW+1)'(0) - q1;
        if (neg_reg[NW-1])
            quot_next = (q1 > LIM) ? WORD_MIN : nq[W-1:0];
        else
            quot_next = (q1 >= LIM) ? WORD_MAX : q1[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule
